// ----- rtl/rrc_pkg.sv -----
// Shared types, codes and helpers of the read request coalescer.
`default_nettype none
package rrc_pkg;

	localparam logic [1:0] CMD_ENQUEUE = 2'd0;
	localparam logic [1:0] CMD_SEND    = 2'd1;
	localparam logic [1:0] CMD_RESULT  = 2'd2;
	localparam logic [1:0] CMD_CLEAR   = 2'd3;

	localparam logic [1:0] RES_ISSUE   = 2'd0;
	localparam logic [1:0] RES_DELIVER = 2'd1;
	localparam logic [1:0] RES_ERROR   = 2'd2;
	localparam logic [1:0] RES_DONE    = 2'd3;

	localparam logic [1:0] ERR_NONE     = 2'd0;
	localparam logic [1:0] ERR_NODATA   = 2'd1;
	localparam logic [1:0] ERR_FAILED   = 2'd2;
	localparam logic [1:0] ERR_OVERFLOW = 2'd3;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_NODATA = 2'd1;

	localparam logic REG_MAX_BYTES = 1'b0;
	localparam logic REG_READ_PRIO = 1'b1;

	localparam logic [31:0] MAX_BYTES_RESET = 32'd8388608;
	localparam logic [5:0]  SEND_CAP = 6'd30;
	localparam logic [5:0]  MAX_RES  = 6'd32;

	typedef struct packed {
		logic [1:0]  kind;
		logic [63:0] blob;
		logic [63:0] tablet;
		logic [7:0]  channel;
		logic [31:0] generation;
		logic [31:0] group;
		logic [25:0] size;
		logic [15:0] requester;
		logic [31:0] cookie;
		logic [1:0]  status;
		logic        message_end;
	} cmd_t;

	typedef struct packed {
		logic [63:0] blob;
		logic [63:0] tablet;
		logic [39:0] chan_gen;
		logic [31:0] group;
		logic [25:0] size;
		logic [47:0] owner;
	} pend_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [63:0] blob;
		logic [31:0] group;
		logic [2:0]  prio;
		logic [15:0] requester;
		logic [31:0] cookie;
		logic        last;
		logic [1:0]  err;
		logic        act;
		logic [39:0] bytes;
	} res_t;

	function automatic res_t mk_res(input logic [1:0] kind, input logic [63:0] blob,
			input logic [31:0] group, input logic [2:0] prio, input logic [47:0] owner,
			input logic [1:0] err, input logic act, input logic [39:0] bytes);
		res_t r;
		r.kind = kind;
		r.blob = blob;
		r.group = group;
		r.prio = prio;
		r.requester = owner[47:32];
		r.cookie = owner[31:0];
		r.last = 1'b0;
		r.err = err;
		r.act = act;
		r.bytes = bytes;
		return r;
	endfunction

endpackage
`default_nettype wire

// ----- rtl/rrc_front.sv -----
// Command front end: accepts words and buffers them in a two-entry queue.
`default_nettype none
module rrc_front (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         start,
	input  wire rrc_pkg::cmd_t cmd_in,
	output logic              busy,
	output logic              cmd_valid,
	output rrc_pkg::cmd_t     cmd_out,
	input  wire logic         cmd_take
);
	import rrc_pkg::*;

	cmd_t       q_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;
	logic       push;
	logic       pop;

	assign busy = (cnt_q == 2'd2);
	assign push = start && !busy;
	assign cmd_valid = (cnt_q != 2'd0);
	assign pop = cmd_take && cmd_valid;
	assign cmd_out = q_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			q_q[wp_q] <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= !wp_q;
			end
			if (pop) begin
				rp_q <= !rp_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule
`default_nettype wire

// ----- rtl/rrc_back.sv -----
// Command back end: pending queue, in-flight table and the sequencer that runs each word.
`default_nettype none
module rrc_back #(
	parameter int PEND_DEPTH = 16,
	parameter int ACT_DEPTH = 32
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cmd_valid,
	input  wire rrc_pkg::cmd_t cmd,
	output logic               cmd_take,
	input  wire logic [31:0]   max_bytes,
	input  wire logic [2:0]    read_prio,
	output rrc_pkg::res_t      res,
	output logic               res_valid
);
	import rrc_pkg::*;

	localparam int PAW = (PEND_DEPTH > 1) ? $clog2(PEND_DEPTH) : 1;
	localparam int AAW = (ACT_DEPTH > 1) ? $clog2(ACT_DEPTH) : 1;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_ESCAN = 4'd1;
	localparam logic [3:0] S_EDEC  = 4'd2;
	localparam logic [3:0] S_RSCAN = 4'd3;
	localparam logic [3:0] S_REND  = 4'd4;
	localparam logic [3:0] S_OUTER = 4'd5;
	localparam logic [3:0] S_HEAD  = 4'd6;
	localparam logic [3:0] S_HCHK  = 4'd7;
	localparam logic [3:0] S_HSCAN = 4'd8;
	localparam logic [3:0] S_HDEC  = 4'd9;
	localparam logic [3:0] S_IEND  = 4'd10;
	localparam logic [3:0] S_FIN   = 4'd11;
	localparam logic [3:0] S_DONE  = 4'd12;
	localparam logic [3:0] S_FLUSH = 4'd13;

	pend_t       pend_mem [PEND_DEPTH];
	logic [63:0] act_blob_mem [ACT_DEPTH];
	logic [47:0] act_own_mem [ACT_DEPTH];

	logic [3:0]           state_q;
	cmd_t                 cur_q;
	pend_t                pr_q;
	logic [63:0]          act_rd_blob_q;
	logic [47:0]          act_rd_own_q;
	logic [PAW-1:0]       head_q;
	logic [PAW:0]         count_q;
	logic [ACT_DEPTH-1:0] valid_q;
	logic [39:0]          bytes_q;
	logic                 skip_q;
	logic [63:0]          key_blob_q;
	logic [63:0]          key_tablet_q;
	logic [39:0]          key_cg_q;
	logic [31:0]          key_group_q;
	logic [AAW:0]         scnt_q;
	logic                 scan_v_s1;
	logic [AAW-1:0]       scan_idx_s1;
	logic                 found_q;
	logic                 started_q;
	logic                 drain_q;
	logic                 stalled_q;
	logic [5:0]           cnt_q;
	res_t                 hold_q;
	logic                 hold_v_q;

	logic           free_any;
	logic [AAW-1:0] free_idx;
	logic           hit;
	logic           last_scan;
	logic           key_match;
	logic [39:0]    bytes_add;
	logic [39:0]    bytes_sub;
	logic [39:0]    max_ext;
	logic           pend_full;
	logic [PAW:0]   tail_sum;
	logic [PAW-1:0] tail;
	logic [PAW-1:0] head_next;
	logic           scanning;
	logic           push_en;
	res_t           push_res;
	logic           act_we;
	logic [63:0]    act_wb;
	logic [47:0]    act_wo;
	logic           pend_we;
	pend_t          pend_wd;

	assign cmd_take = (state_q == S_IDLE);
	assign max_ext = {8'd0, max_bytes};
	assign bytes_add = bytes_q + {14'd0, pr_q.size};
	assign bytes_sub = (bytes_q > {14'd0, cur_q.size}) ? (bytes_q - {14'd0, cur_q.size}) : 40'd0;
	assign pend_full = (count_q == (PAW+1)'(PEND_DEPTH));
	assign tail_sum = {1'b0, head_q} + count_q;
	assign tail = (tail_sum >= (PAW+1)'(PEND_DEPTH)) ?
		PAW'(tail_sum - (PAW+1)'(PEND_DEPTH)) : tail_sum[PAW-1:0];
	assign head_next = (head_q == PAW'(PEND_DEPTH - 1)) ? '0 : head_q + PAW'(1);
	assign hit = scan_v_s1 && valid_q[scan_idx_s1] && (act_rd_blob_q == key_blob_q);
	assign last_scan = scan_v_s1 && (scan_idx_s1 == AAW'(ACT_DEPTH - 1));
	assign key_match = (pr_q.tablet == key_tablet_q) && (pr_q.chan_gen == key_cg_q) &&
		(pr_q.group == key_group_q);
	assign scanning = (state_q == S_ESCAN) || (state_q == S_RSCAN) || (state_q == S_HSCAN);

	always_comb begin
		free_any = 1'b0;
		free_idx = '0;
		for (int i = ACT_DEPTH - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_any = 1'b1;
				free_idx = AAW'(i);
			end
		end
	end

	always_comb begin
		push_en = 1'b0;
		push_res = mk_res(RES_ERROR, 64'd0, 32'd0, 3'd0, 48'd0, ERR_NONE, 1'b0, bytes_q);
		act_we = 1'b0;
		act_wb = pr_q.blob;
		act_wo = pr_q.owner;
		pend_we = 1'b0;
		pend_wd.blob = cur_q.blob;
		pend_wd.tablet = cur_q.tablet;
		pend_wd.chan_gen = {cur_q.channel, cur_q.generation};
		pend_wd.group = cur_q.group;
		pend_wd.size = cur_q.size;
		pend_wd.owner = {cur_q.requester, cur_q.cookie};
		case (state_q)
			S_IDLE: begin
				if (cmd_valid && cmd.kind == CMD_RESULT && !skip_q && cmd.status != ST_OK) begin
					push_en = 1'b1;
					push_res = mk_res(RES_ERROR, cmd.blob, 32'd0, 3'd0, 48'd0,
						(cmd.status == ST_NODATA) ? ERR_NODATA : ERR_FAILED, 1'b0, bytes_q);
				end
			end
			S_EDEC: begin
				if (found_q) begin
					if (free_any) begin
						act_we = 1'b1;
						act_wb = cur_q.blob;
						act_wo = {cur_q.requester, cur_q.cookie};
					end else begin
						push_en = 1'b1;
						push_res = mk_res(RES_ERROR, cur_q.blob, 32'd0, 3'd0, 48'd0,
							ERR_OVERFLOW, 1'b0, bytes_q);
					end
				end else if (pend_full) begin
					push_en = 1'b1;
					push_res = mk_res(RES_ERROR, cur_q.blob, 32'd0, 3'd0, 48'd0,
						ERR_OVERFLOW, 1'b0, bytes_q);
				end else begin
					pend_we = 1'b1;
				end
			end
			S_RSCAN: begin
				if (hit && cnt_q < MAX_RES) begin
					push_en = 1'b1;
					push_res = mk_res(RES_DELIVER, cur_q.blob, 32'd0, 3'd0, act_rd_own_q,
						ERR_NONE, 1'b0, (cnt_q == 6'd0) ? bytes_sub : bytes_q);
				end
			end
			S_HDEC: begin
				if (found_q) begin
					act_we = free_any;
				end else if (!drain_q && !(started_q && !key_match) && cnt_q < SEND_CAP &&
						free_any) begin
					act_we = 1'b1;
					push_en = 1'b1;
					push_res = mk_res(RES_ISSUE, pr_q.blob, pr_q.group, read_prio, 48'd0,
						ERR_NONE, 1'b0, bytes_add);
				end
			end
			S_FIN: begin
				if (stalled_q) begin
					push_en = 1'b1;
					push_res = mk_res(RES_ERROR, pr_q.blob, 32'd0, 3'd0, 48'd0,
						ERR_OVERFLOW, 1'b0, bytes_q);
				end
			end
			S_DONE: begin
				push_en = 1'b1;
				push_res = mk_res(RES_DONE, 64'd0, 32'd0, 3'd0, 48'd0, ERR_NONE,
					|valid_q, bytes_q);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (pend_we) begin
			pend_mem[tail] <= pend_wd;
		end
		pr_q <= pend_mem[head_q];
	end

	always_ff @(posedge clk) begin
		if (act_we) begin
			act_blob_mem[free_idx] <= act_wb;
			act_own_mem[free_idx] <= act_wo;
		end
		act_rd_blob_q <= act_blob_mem[scnt_q[AAW-1:0]];
		act_rd_own_q <= act_own_mem[scnt_q[AAW-1:0]];
	end

	always_ff @(posedge clk) begin
		cur_q <= (state_q == S_IDLE) ? cmd : cur_q;
		if (state_q == S_IDLE && cmd_valid) begin
			key_blob_q <= cmd.blob;
		end else if (state_q == S_HCHK) begin
			key_blob_q <= pr_q.blob;
		end
		if (state_q == S_HDEC && !found_q && !started_q) begin
			key_tablet_q <= pr_q.tablet;
			key_cg_q <= pr_q.chan_gen;
			key_group_q <= pr_q.group;
		end
		scan_idx_s1 <= scnt_q[AAW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q <= '0;
			count_q <= '0;
			valid_q <= '0;
			bytes_q <= '0;
			skip_q <= 1'b0;
			scnt_q <= '0;
			scan_v_s1 <= 1'b0;
			found_q <= 1'b0;
			started_q <= 1'b0;
			drain_q <= 1'b0;
			stalled_q <= 1'b0;
			cnt_q <= '0;
			hold_q <= '0;
			hold_v_q <= 1'b0;
			res <= '0;
			res_valid <= 1'b0;
		end else begin
			res_valid <= 1'b0;
			if (push_en) begin
				if (hold_v_q) begin
					res <= hold_q;
					res_valid <= 1'b1;
				end
				hold_q <= push_res;
				hold_v_q <= 1'b1;
			end
			if (scanning && scnt_q < (AAW+1)'(ACT_DEPTH)) begin
				scnt_q <= scnt_q + (AAW+1)'(1);
				scan_v_s1 <= 1'b1;
			end else begin
				scan_v_s1 <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						case (cmd.kind)
							CMD_ENQUEUE: begin
								scnt_q <= '0;
								state_q <= S_ESCAN;
							end
							CMD_SEND: begin
								cnt_q <= '0;
								stalled_q <= 1'b0;
								state_q <= S_OUTER;
							end
							CMD_RESULT: begin
								if (skip_q) begin
									if (cmd.message_end) begin
										skip_q <= 1'b0;
									end
								end else if (cmd.status != ST_OK) begin
									skip_q <= !cmd.message_end;
									state_q <= S_FLUSH;
								end else begin
									scnt_q <= '0;
									cnt_q <= '0;
									state_q <= S_RSCAN;
								end
							end
							default: begin
								head_q <= '0;
								count_q <= '0;
								valid_q <= '0;
								bytes_q <= '0;
								skip_q <= 1'b0;
							end
						endcase
					end
				end
				S_ESCAN: begin
					if (hit) begin
						found_q <= 1'b1;
						state_q <= S_EDEC;
					end else if (last_scan) begin
						found_q <= 1'b0;
						state_q <= S_EDEC;
					end
				end
				S_EDEC: begin
					if (found_q && free_any) begin
						valid_q[free_idx] <= 1'b1;
					end
					if (!found_q && !pend_full) begin
						count_q <= count_q + (PAW+1)'(1);
					end
					state_q <= S_FLUSH;
				end
				S_RSCAN: begin
					if (hit && cnt_q < MAX_RES) begin
						valid_q[scan_idx_s1] <= 1'b0;
						cnt_q <= cnt_q + 6'd1;
						if (cnt_q == 6'd0) begin
							bytes_q <= bytes_sub;
						end
					end
					if (last_scan) begin
						state_q <= S_REND;
					end
				end
				S_REND: begin
					if (cnt_q != 6'd0) begin
						hold_q.last <= 1'b1;
					end
					state_q <= S_FLUSH;
				end
				S_OUTER: begin
					if (bytes_q < max_ext && count_q != '0 && cnt_q < SEND_CAP) begin
						started_q <= 1'b0;
						drain_q <= 1'b0;
					end else begin
						drain_q <= 1'b1;
					end
					state_q <= S_HEAD;
				end
				S_HEAD: begin
					state_q <= S_HCHK;
				end
				S_HCHK: begin
					if (count_q == '0) begin
						state_q <= drain_q ? S_FIN : S_IEND;
					end else begin
						scnt_q <= '0;
						state_q <= S_HSCAN;
					end
				end
				S_HSCAN: begin
					if (hit) begin
						found_q <= 1'b1;
						state_q <= S_HDEC;
					end else if (last_scan) begin
						found_q <= 1'b0;
						state_q <= S_HDEC;
					end
				end
				S_HDEC: begin
					if (found_q) begin
						if (free_any) begin
							valid_q[free_idx] <= 1'b1;
							head_q <= head_next;
							count_q <= count_q - (PAW+1)'(1);
							state_q <= S_HEAD;
						end else begin
							stalled_q <= 1'b1;
							state_q <= drain_q ? S_FIN : S_IEND;
						end
					end else if (drain_q) begin
						state_q <= S_FIN;
					end else if (started_q && !key_match) begin
						state_q <= S_IEND;
					end else if (cnt_q >= SEND_CAP) begin
						state_q <= S_IEND;
					end else if (!free_any) begin
						stalled_q <= 1'b1;
						state_q <= S_IEND;
					end else begin
						bytes_q <= bytes_add;
						started_q <= 1'b1;
						valid_q[free_idx] <= 1'b1;
						head_q <= head_next;
						count_q <= count_q - (PAW+1)'(1);
						cnt_q <= cnt_q + 6'd1;
						state_q <= (bytes_add > max_ext) ? S_IEND : S_HEAD;
					end
				end
				S_IEND: begin
					if (started_q) begin
						hold_q.last <= 1'b1;
					end
					state_q <= stalled_q ? S_FIN : S_OUTER;
				end
				S_FIN: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					state_q <= S_FLUSH;
				end
				S_FLUSH: begin
					if (hold_v_q) begin
						res <= hold_q;
						res_valid <= 1'b1;
						hold_v_q <= 1'b0;
					end
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// ----- rtl/read_request_coalescer_core.sv -----
// Top level of the read request coalescer: ports, configuration registers and checks.
// An enqueue, an OK blob result and each pending entry that a send walks search the in-flight
// table, one entry a cycle; deliveries are produced during the table search.
// Two words may queue. Results leave at most one per cycle with a strobe; no stall.
// Reset is asynchronous: queues and table empty, byte count zero, credit 8388608.
`default_nettype none
module read_request_coalescer_core #(
	parameter int PEND_DEPTH = 16,
	parameter int ACT_DEPTH = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  kind,
	input  wire logic [63:0] blob_id,
	input  wire logic [63:0] tablet_id,
	input  wire logic [7:0]  channel,
	input  wire logic [31:0] generation,
	input  wire logic [31:0] group,
	input  wire logic [25:0] blob_size,
	input  wire logic [15:0] requester,
	input  wire logic [31:0] cookie,
	input  wire logic [1:0]  status,
	input  wire logic        message_end,
	input  wire logic        cfg_write,
	input  wire logic        cfg_index,
	input  wire logic [31:0] cfg_data,
	output logic             valid,
	output logic [1:0]       out_kind,
	output logic [63:0]      out_blob_id,
	output logic [31:0]      out_group,
	output logic [2:0]       out_priority,
	output logic [15:0]      out_requester,
	output logic [31:0]      out_cookie,
	output logic             last,
	output logic [1:0]       error_code,
	output logic             active_nonempty,
	output logic [39:0]      bytes_outstanding
);
	import rrc_pkg::*;

	cmd_t        cmd_in;
	cmd_t        cmd_q;
	logic        cmd_valid;
	logic        cmd_take;
	res_t        res;
	logic [31:0] max_q;
	logic [2:0]  prio_q;

	assign cmd_in.kind = kind;
	assign cmd_in.blob = blob_id;
	assign cmd_in.tablet = tablet_id;
	assign cmd_in.channel = channel;
	assign cmd_in.generation = generation;
	assign cmd_in.group = group;
	assign cmd_in.size = blob_size;
	assign cmd_in.requester = requester;
	assign cmd_in.cookie = cookie;
	assign cmd_in.status = status;
	assign cmd_in.message_end = message_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= MAX_BYTES_RESET;
			prio_q <= 3'd0;
		end else if (cfg_write) begin
			if (cfg_index == REG_MAX_BYTES) begin
				max_q <= cfg_data;
			end else begin
				prio_q <= cfg_data[2:0];
			end
		end
	end

	rrc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.cmd_in    (cmd_in),
		.busy      (busy),
		.cmd_valid (cmd_valid),
		.cmd_out   (cmd_q),
		.cmd_take  (cmd_take)
	);

	rrc_back #(
		.PEND_DEPTH (PEND_DEPTH),
		.ACT_DEPTH  (ACT_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd_q),
		.cmd_take  (cmd_take),
		.max_bytes (max_q),
		.read_prio (prio_q),
		.res       (res),
		.res_valid (valid)
	);

	assign out_kind = res.kind;
	assign out_blob_id = res.blob;
	assign out_group = res.group;
	assign out_priority = res.prio;
	assign out_requester = res.requester;
	assign out_cookie = res.cookie;
	assign last = res.last;
	assign error_code = res.err;
	assign active_nonempty = res.act;
	assign bytes_outstanding = res.bytes;

	a_issue_prio: assert property (@(posedge clk) disable iff (!arst_n)
		valid && out_kind == RES_ISSUE |-> out_priority == prio_q)
		else $error("issued read carries a stale priority");

	a_done_clean: assert property (@(posedge clk) disable iff (!arst_n)
		valid && out_kind == RES_DONE |-> out_blob_id == 64'd0 && !last)
		else $error("send done word is not clean");

	a_deliver_noerr: assert property (@(posedge clk) disable iff (!arst_n)
		valid && out_kind == RES_DELIVER |-> error_code == ERR_NONE && out_group == 32'd0)
		else $error("delivery word carries error or group");

	a_busy_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("queue filled without an accepted word");

endmodule
`default_nettype wire

// ----- bench/testbench.sv -----
// Self-checking testbench of the read request coalescer: directed cases, then random traffic.
`default_nettype none
module testbench;
	import rrc_pkg::*;

	localparam int PDEPTH = 16;
	localparam int ADEPTH = 32;
	localparam int CYCLE_LIMIT = 3000000;
	localparam int EXP_DEPTH = 4096;
	localparam logic [1:0] ST_OTHER = 2'd2;

	logic clk, arst_n, start, busy;
	logic [1:0] kind;
	logic [63:0] blob_id, tablet_id;
	logic [7:0] channel;
	logic [31:0] generation, group;
	logic [25:0] blob_size;
	logic [15:0] requester;
	logic [31:0] cookie;
	logic [1:0] status;
	logic message_end;
	logic cfg_write, cfg_index;
	logic [31:0] cfg_data;
	logic valid, last, active_nonempty;
	logic [1:0] out_kind, error_code;
	logic [63:0] out_blob_id;
	logic [31:0] out_group, out_cookie;
	logic [2:0] out_priority;
	logic [15:0] out_requester;
	logic [39:0] bytes_outstanding;

	read_request_coalescer_core uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .kind(kind),
		.blob_id(blob_id), .tablet_id(tablet_id), .channel(channel),
		.generation(generation), .group(group), .blob_size(blob_size),
		.requester(requester), .cookie(cookie), .status(status),
		.message_end(message_end), .cfg_write(cfg_write), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .valid(valid), .out_kind(out_kind),
		.out_blob_id(out_blob_id), .out_group(out_group), .out_priority(out_priority),
		.out_requester(out_requester), .out_cookie(out_cookie), .last(last),
		.error_code(error_code), .active_nonempty(active_nonempty),
		.bytes_outstanding(bytes_outstanding)
	);

	// Model state of the coalescer.
	logic [63:0] pq_blob[PDEPTH];
	logic [63:0] pq_tablet[PDEPTH];
	logic [39:0] pq_cg[PDEPTH];
	logic [31:0] pq_group[PDEPTH];
	logic [25:0] pq_size[PDEPTH];
	logic [47:0] pq_owner[PDEPTH];
	int pq_head, pq_count;
	logic [63:0] fl_blob[ADEPTH];
	logic [47:0] fl_owner[ADEPTH];
	bit fl_valid[ADEPTH];
	logic [39:0] fly_bytes;
	bit skipping;
	logic [31:0] credit;
	logic [2:0] prio_reg;

	res_t exp_mem[EXP_DEPTH];
	int exp_wr, exp_rd;
	int mismatches, words_seen, items_sent, cycles, burst_left;
	logic [63:0] blob_pool[12];
	logic [63:0] key_tab[3];
	logic [39:0] key_cg[3];
	logic [31:0] key_grp[3];

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("testbench: done, errors");
			$finish;
		end
	end

	function automatic int flight_slot(logic [63:0] b);
		for (int i = 0; i < ADEPTH; i++)
			if (fl_valid[i] && fl_blob[i] == b)
				return i;
		return -1;
	endfunction

	function automatic int free_slot();
		for (int i = 0; i < ADEPTH; i++)
			if (!fl_valid[i])
				return i;
		return -1;
	endfunction

	function automatic bit any_flight();
		for (int i = 0; i < ADEPTH; i++)
			if (fl_valid[i])
				return 1'b1;
		return 1'b0;
	endfunction

	function automatic void expect_word(logic [1:0] k, logic [63:0] b, logic [31:0] g,
			logic [2:0] p, logic [47:0] own, logic [1:0] e, logic a);
		res_t r;
		r.kind = k;
		r.blob = b;
		r.group = g;
		r.prio = p;
		r.requester = own[47:32];
		r.cookie = own[31:0];
		r.last = 1'b0;
		r.err = e;
		r.act = a;
		r.bytes = fly_bytes;
		exp_mem[exp_wr % EXP_DEPTH] = r;
		exp_wr++;
	endfunction

	function automatic void mark_last();
		exp_mem[(exp_wr - 1) % EXP_DEPTH].last = 1'b1;
	endfunction

	function automatic bit head_to_flight();
		int s;
		s = free_slot();
		if (s < 0)
			return 1'b0;
		fl_blob[s] = pq_blob[pq_head];
		fl_owner[s] = pq_owner[pq_head];
		fl_valid[s] = 1'b1;
		pq_head = (pq_head + 1) % PDEPTH;
		pq_count--;
		return 1'b1;
	endfunction

	function automatic void predict_send();
		int n, h;
		bit stalled, started;
		logic [63:0] kt;
		logic [39:0] kcg;
		logic [31:0] kg;
		n = 0;
		stalled = 1'b0;
		kt = '0;
		kcg = '0;
		kg = '0;
		while (!stalled && fly_bytes < {8'd0, credit} && pq_count > 0 && n < SEND_CAP) begin
			started = 1'b0;
			while (pq_count > 0) begin
				h = pq_head;
				if (flight_slot(pq_blob[h]) >= 0) begin
					if (!head_to_flight()) begin
						stalled = 1'b1;
						break;
					end
					continue;
				end
				if (started) begin
					if (kt != pq_tablet[h] || kcg != pq_cg[h] || kg != pq_group[h])
						break;
				end else begin
					kt = pq_tablet[h];
					kcg = pq_cg[h];
					kg = pq_group[h];
				end
				if (n >= SEND_CAP)
					break;
				if (free_slot() < 0) begin
					stalled = 1'b1;
					break;
				end
				fly_bytes = fly_bytes + {14'd0, pq_size[h]};
				expect_word(RES_ISSUE, pq_blob[h], kg, prio_reg, '0, ERR_NONE, 1'b0);
				n++;
				started = 1'b1;
				void'(head_to_flight());
				if (fly_bytes > {8'd0, credit})
					break;
			end
			if (started)
				mark_last();
		end
		while (!stalled && pq_count > 0 && flight_slot(pq_blob[pq_head]) >= 0)
			if (!head_to_flight())
				stalled = 1'b1;
		if (stalled)
			expect_word(RES_ERROR, pq_blob[pq_head], '0, '0, '0, ERR_OVERFLOW, 1'b0);
		expect_word(RES_DONE, '0, '0, '0, '0, ERR_NONE, any_flight());
	endfunction

	function automatic void predict_result(cmd_t c);
		bit hit;
		if (skipping) begin
			if (c.message_end)
				skipping = 1'b0;
			return;
		end
		if (c.status != ST_OK) begin
			skipping = !c.message_end;
			expect_word(RES_ERROR, c.blob, '0, '0, '0,
				c.status == ST_NODATA ? ERR_NODATA : ERR_FAILED, 1'b0);
			return;
		end
		if (flight_slot(c.blob) < 0)
			return;
		fly_bytes = fly_bytes > {14'd0, c.size} ? fly_bytes - {14'd0, c.size} : '0;
		hit = 1'b0;
		for (int i = 0; i < ADEPTH; i++)
			if (fl_valid[i] && fl_blob[i] == c.blob) begin
				fl_valid[i] = 1'b0;
				expect_word(RES_DELIVER, c.blob, '0, '0, fl_owner[i], ERR_NONE, 1'b0);
				hit = 1'b1;
			end
		if (hit)
			mark_last();
	endfunction

	function automatic void predict_word(cmd_t c);
		int s, t;
		case (c.kind)
			CMD_ENQUEUE: begin
				if (flight_slot(c.blob) >= 0) begin
					s = free_slot();
					if (s < 0)
						expect_word(RES_ERROR, c.blob, '0, '0, '0, ERR_OVERFLOW, 1'b0);
					else begin
						fl_blob[s] = c.blob;
						fl_owner[s] = {c.requester, c.cookie};
						fl_valid[s] = 1'b1;
					end
				end else if (pq_count >= PDEPTH)
					expect_word(RES_ERROR, c.blob, '0, '0, '0, ERR_OVERFLOW, 1'b0);
				else begin
					t = (pq_head + pq_count) % PDEPTH;
					pq_blob[t] = c.blob;
					pq_tablet[t] = c.tablet;
					pq_cg[t] = {c.channel, c.generation};
					pq_group[t] = c.group;
					pq_size[t] = c.size;
					pq_owner[t] = {c.requester, c.cookie};
					pq_count++;
				end
			end
			CMD_SEND: predict_send();
			CMD_RESULT: predict_result(c);
			default: begin
				pq_head = 0;
				pq_count = 0;
				for (int i = 0; i < ADEPTH; i++)
					fl_valid[i] = 1'b0;
				fly_bytes = '0;
				skipping = 1'b0;
			end
		endcase
	endfunction

	always @(posedge clk) begin
		res_t got, want;
		if (arst_n && valid) begin
			words_seen++;
			got.kind = out_kind;
			got.blob = out_blob_id;
			got.group = out_group;
			got.prio = out_priority;
			got.requester = out_requester;
			got.cookie = out_cookie;
			got.last = last;
			got.err = error_code;
			got.act = active_nonempty;
			got.bytes = bytes_outstanding;
			if (exp_wr == exp_rd) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected word: %h", got);
			end else begin
				want = exp_mem[exp_rd % EXP_DEPTH];
				exp_rd++;
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %h, actual %h", want, got);
				end
			end
		end
	end

	function automatic cmd_t noise();
		cmd_t c;
		c.kind = 2'($urandom_range(0, 3));
		c.blob = {$urandom, $urandom};
		c.tablet = {$urandom, $urandom};
		c.channel = 8'($urandom);
		c.generation = $urandom;
		c.group = $urandom;
		c.size = 26'($urandom);
		c.requester = 16'($urandom);
		c.cookie = $urandom;
		c.status = 2'($urandom_range(0, 2));
		c.message_end = 1'($urandom);
		return c;
	endfunction

	function automatic cmd_t enq(logic [63:0] b, int key, logic [25:0] sz);
		cmd_t c;
		c = noise();
		c.kind = CMD_ENQUEUE;
		c.blob = b;
		c.tablet = key_tab[key];
		{c.channel, c.generation} = key_cg[key];
		c.group = key_grp[key];
		c.size = sz;
		return c;
	endfunction

	function automatic cmd_t cmd_of(logic [1:0] k);
		cmd_t c;
		c = noise();
		c.kind = k;
		return c;
	endfunction

	function automatic cmd_t blob_done(logic [63:0] b, logic [25:0] sz, logic [1:0] st,
			logic fin);
		cmd_t c;
		c = noise();
		c.kind = CMD_RESULT;
		c.blob = b;
		c.size = sz;
		c.status = st;
		c.message_end = fin;
		return c;
	endfunction

	// Called at a rising edge; returns at the edge where the word was taken, or after a random idle gap that ends a burst.
	task automatic send_word(cmd_t c);
		int gap;
		start <= 1'b1;
		kind <= c.kind;
		blob_id <= c.blob;
		tablet_id <= c.tablet;
		channel <= c.channel;
		generation <= c.generation;
		group <= c.group;
		blob_size <= c.size;
		requester <= c.requester;
		cookie <= c.cookie;
		status <= c.status;
		message_end <= c.message_end;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		predict_word(c);
		items_sent++;
		burst_left--;
		if (burst_left <= 0) begin
			gap = $urandom_range(0, 15);
			if (gap > 0) begin
				start <= 1'b0;
				repeat (gap)
					@(posedge clk);
			end
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40)
				: $urandom_range(1, 8);
		end
	endtask

	task automatic settle();
		start <= 1'b0;
		@(posedge clk);
		while (exp_wr != exp_rd)
			@(posedge clk);
		repeat (150)
			@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [31:0] data);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_write <= 1'b0;
		if (idx == REG_MAX_BYTES)
			credit = data;
		else
			prio_reg = data[2:0];
		@(posedge clk);
	endtask

	task automatic test_directed();
		write_reg(REG_MAX_BYTES, 32'hFFFF_FFFF);
		write_reg(REG_READ_PRIO, 32'd7);
		send_word(enq(64'd1, 0, 26'd100));
		send_word(enq(64'd2, 0, 26'd200));
		send_word(enq(64'd1, 0, 26'd100));
		send_word(enq(64'hFFFF_FFFF_FFFF_FFFF, 1, 26'h3FF_FFFF));
		send_word(enq(64'd0, 2, 26'd0));
		send_word(cmd_of(CMD_SEND));
		send_word(enq(64'd2, 1, 26'd5));
		send_word(blob_done(64'd1, 26'd100, ST_OK, 1'b1));
		send_word(blob_done(64'd77, 26'd9, ST_OK, 1'b1));
		send_word(blob_done(64'd2, 26'h3FF_FFFF, ST_OK, 1'b0));
		send_word(blob_done(64'd0, 26'd1, ST_NODATA, 1'b0));
		send_word(blob_done(64'hFFFF_FFFF_FFFF_FFFF, 26'd1, ST_OK, 1'b0));
		send_word(blob_done(64'd0, 26'd1, ST_OK, 1'b1));
		send_word(blob_done(64'd5, 26'd1, ST_OTHER, 1'b1));
		send_word(blob_done(64'd0, 26'd0, ST_OK, 1'b1));
		send_word(cmd_of(CMD_CLEAR));
		settle();
		write_reg(REG_MAX_BYTES, 32'd0);
		write_reg(REG_READ_PRIO, 32'd0);
		send_word(enq(64'd9, 0, 26'd1));
		send_word(cmd_of(CMD_SEND));
		settle();
		write_reg(REG_MAX_BYTES, 32'd150);
		send_word(enq(64'd10, 0, 26'd100));
		send_word(enq(64'd11, 0, 26'd100));
		send_word(enq(64'd12, 0, 26'd100));
		send_word(cmd_of(CMD_SEND));
		send_word(cmd_of(CMD_SEND));
		send_word(cmd_of(CMD_CLEAR));
		settle();
	endtask

	task automatic test_pending_full();
		write_reg(REG_MAX_BYTES, 32'hFFFF_FFFF);
		for (int i = 0; i < PDEPTH + 2; i++)
			send_word(enq(64'd100 + 64'(i), i % 2, 26'd10));
		send_word(cmd_of(CMD_SEND));
		send_word(cmd_of(CMD_CLEAR));
		settle();
	endtask

	task automatic test_table_full();
		for (int i = 0; i < PDEPTH; i++)
			send_word(enq(64'd200 + 64'(i), 0, 26'd1));
		send_word(cmd_of(CMD_SEND));
		for (int i = 0; i < ADEPTH - PDEPTH; i++)
			send_word(enq(64'd200, 1, 26'd1));
		send_word(enq(64'd201, 0, 26'd1));
		send_word(enq(64'd300, 0, 26'd1));
		send_word(cmd_of(CMD_SEND));
		send_word(blob_done(64'd200, 26'd1, ST_OK, 1'b1));
		send_word(cmd_of(CMD_SEND));
		send_word(cmd_of(CMD_CLEAR));
		send_word(enq(64'd400, 0, 26'd1));
		send_word(cmd_of(CMD_SEND));
		for (int i = 0; i < ADEPTH - 1; i++)
			send_word(enq(64'd400, 2, 26'd1));
		send_word(blob_done(64'd400, 26'd1, ST_OK, 1'b1));
		send_word(cmd_of(CMD_CLEAR));
		settle();
	endtask

	task automatic test_random(int count);
		cmd_t c;
		int pick;
		logic [25:0] sz;
		for (int i = 0; i < 12; i++)
			blob_pool[i] = (i < 6) ? 64'(i) : {$urandom, $urandom};
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(0, 99);
			case ($urandom_range(0, 9))
				0: sz = 26'h3FF_FFFF;
				1, 2: sz = 26'($urandom);
				default: sz = 26'($urandom_range(1, 4096));
			endcase
			if (pick < 8)
				c = noise();
			else if (pick < 55)
				c = enq(blob_pool[$urandom_range(0, 11)], $urandom_range(0, 2), sz);
			else if (pick < 72)
				c = cmd_of(CMD_SEND);
			else if (pick < 98)
				c = blob_done(blob_pool[$urandom_range(0, 11)], sz,
					($urandom_range(0, 7) == 0) ? 2'($urandom_range(1, 2)) : ST_OK,
					$urandom_range(0, 3) != 0);
			else
				c = cmd_of(CMD_CLEAR);
			send_word(c);
		end
		settle();
	endtask

	task automatic test_settings();
		logic [31:0] credits[5];
		credits = '{32'd8388608, 32'd0, 32'd5000, 32'hFFFF_FFFF, 32'd0};
		credits[4] = $urandom;
		for (int p = 0; p < 5; p++) begin
			for (int k = 0; k < 3; k++) begin
				key_tab[k] = {$urandom, $urandom};
				key_cg[k] = {8'($urandom), 32'($urandom)};
				key_grp[k] = $urandom;
			end
			write_reg(REG_MAX_BYTES, credits[p]);
			write_reg(REG_READ_PRIO, (p == 4) ? 32'($urandom_range(0, 7)) : 32'(p * 2 + 1));
			test_random(p == 1 ? 40 : 50);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		kind = '0;
		blob_id = '0;
		tablet_id = '0;
		channel = '0;
		generation = '0;
		group = '0;
		blob_size = '0;
		requester = '0;
		cookie = '0;
		status = '0;
		message_end = 1'b0;
		cfg_write = 1'b0;
		cfg_index = 1'b0;
		cfg_data = '0;
		cycles = 0;
		mismatches = 0;
		words_seen = 0;
		items_sent = 0;
		burst_left = 4;
		exp_wr = 0;
		exp_rd = 0;
		pq_head = 0;
		pq_count = 0;
		for (int i = 0; i < ADEPTH; i++)
			fl_valid[i] = 1'b0;
		fly_bytes = '0;
		skipping = 1'b0;
		credit = MAX_BYTES_RESET;
		prio_reg = '0;
		key_tab = '{64'd0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h1234};
		key_cg = '{40'd0, 40'hFF_FFFF_FFFF, 40'h01_0000_0002};
		key_grp = '{32'd0, 32'hFFFF_FFFF, 32'd7};
		repeat (2)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_pending_full();
		test_table_full();
		test_settings();
		settle();
		mismatches += exp_wr - exp_rd;
		$display("Sent %0d words and checked %0d results over five credit and priority settings,",
			items_sent, words_seen);
		$display("including full queue, full table, many waiters and skipped error messages.");
		if (mismatches == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule
`default_nettype wire

// ----- filelist.f -----
rtl/rrc_pkg.sv
rtl/rrc_front.sv
rtl/rrc_back.sv
rtl/read_request_coalescer_core.sv
bench/testbench.sv
